// ===== rtl/rle8_bitmap_decoder_core_macros.svh =====
// assertion macros for the checker file
`ifndef RLE8_BITMAP_DECODER_CORE_MACROS_SVH
`define RLE8_BITMAP_DECODER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RLE8_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RLE8_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rle8_pkg.sv =====
// shared types and constants of the rle8 bitmap decoder
package rle8_pkg;

	localparam int unsigned REQ_W      = 2;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned COLOR_W    = 24;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ADDR_W     = 24;
	localparam int unsigned LEN_W      = 8;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned CNT_W      = 24;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned DIM_W      = 13;
	localparam int unsigned PROD_W     = 25;

	typedef logic [REQ_W-1:0]     req_t;
	typedef logic [STAT_W-1:0]    status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam req_t REQ_PAL   = 2'd0;
	localparam req_t REQ_BYTE  = 2'd1;
	localparam req_t REQ_START = 2'd2;

	localparam status_t STAT_EOB   = 2'd0;
	localparam status_t STAT_ROWS  = 2'd1;
	localparam status_t STAT_DELTA = 2'd2;

	localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
	localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
	localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

	localparam cfg_idx_t CFG_WIDTH  = 1'b0;
	localparam cfg_idx_t CFG_HEIGHT = 1'b1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// image geometry derived from the configuration registers
	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [PROD_W-1:0] limit;
		logic [PROD_W-1:0] start;
	} geom_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [IDX_W-1:0]   addr;
		logic [COLOR_W-1:0] wdata;
	} pal_req_t;

	// parsed result waiting for its palette colour
	typedef struct packed {
		logic [ADDR_W-1:0] pixel_addr;
		logic [LEN_W-1:0]  run_len;
		logic              done_res;
		status_t           status;
		logic [CNT_W-1:0]  bytes_used;
		logic              use_pal;
	} res_t;

endpackage

// ===== rtl/rle8_if.sv =====
// request and result channel interfaces
interface rle8_in_if;
	import rle8_pkg::*;

	logic               valid;
	logic               ready;
	req_t               req_type;
	logic [IDX_W-1:0]   pal_index;
	logic [COLOR_W-1:0] pal_color;
	logic [BYTE_W-1:0]  data_byte;

	modport source (output valid, req_type, pal_index, pal_color, data_byte, input ready);
	modport sink (input valid, req_type, pal_index, pal_color, data_byte, output ready);
endinterface

interface rle8_out_if;
	import rle8_pkg::*;

	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  pixel_addr;
	logic [LEN_W-1:0]   run_len;
	logic [COLOR_W-1:0] color;
	logic               done_res;
	status_t            status;
	logic [CNT_W-1:0]   bytes_used;

	modport source (output valid, pixel_addr, run_len, color, done_res, status, bytes_used,
		input ready);
	modport sink (input valid, pixel_addr, run_len, color, done_res, status, bytes_used,
		output ready);
endinterface

// ===== rtl/rle8_cfg.sv =====
// configuration registers and derived image geometry
module rle8_cfg #(
	parameter int MAX_DIM = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  rle8_pkg::cfg_idx_t            cfg_index,
	input  logic [rle8_pkg::CFG_DATA_W-1:0] cfg_data,
	output rle8_pkg::geom_t               geom
);
	import rle8_pkg::*;

	logic [DIM_W-1:0]  clamped;
	logic [DIM_W-1:0]  new_w;
	logic [DIM_W-1:0]  new_h;
	logic [PROD_W-1:0] new_prod;
	geom_t             geom_q;

	assign clamped  = (cfg_data > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_data;
	assign new_w    = (cfg_index == CFG_WIDTH) ? clamped : geom_q.width;
	assign new_h    = (cfg_index == CFG_HEIGHT) ? clamped : geom_q.height;
	assign new_prod = PROD_W'(new_w) * PROD_W'(new_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.width  <= DIM_W'(1);
			geom_q.height <= DIM_W'(1);
			geom_q.limit  <= PROD_W'(1);
			geom_q.start  <= '0;
		end else if (cfg_we) begin
			geom_q.width  <= new_w;
			geom_q.height <= new_h;
			geom_q.limit  <= new_prod;
			// first pixel of the bottom row is w*h - w
			geom_q.start  <= (new_h == '0) ? '0 : new_prod - PROD_W'(new_w);
		end
	end

	assign geom = geom_q;
endmodule

// ===== rtl/rle8_parser.sv =====
// stream byte parser, pixel pointers and parse result register
module rle8_parser #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rle8_pkg::geom_t               geom,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rle8_pkg::req_t                req_type,
	input  logic [rle8_pkg::IDX_W-1:0]    pal_index,
	input  logic [rle8_pkg::COLOR_W-1:0]  pal_color,
	input  logic [rle8_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          take,
	output rle8_pkg::pal_req_t            pal_req,
	output logic                          valid_s1,
	output rle8_pkg::res_t                res_s1
);
	import rle8_pkg::*;

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_COLOR,
		PH_ESCAPE,
		PH_LITERAL,
		PH_PAD
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [BYTE_W-1:0]  pend_q, pend_d;
	logic [BYTE_W-1:0]  lit_q, lit_d;
	logic               odd_q, odd_d;
	logic [PROD_W-1:0]  wp_q, wp_d;
	logic [PROD_W-1:0]  rs_q, rs_d;
	logic [DIM_W-1:0]   rows_q, rows_d;
	logic [CNT_W-1:0]   bc_q, bc_d;
	logic               fin_q, fin_d;
	logic               res_v;
	res_t               res_d;

	logic               accept;
	logic               in_pal;
	logic [PROD_W-1:0]  room;
	logic [LEN_W-1:0]   run_cnt;
	logic [LEN_W-1:0]   run_n;
	logic [PROD_W-1:0]  wp_run;
	logic [PROD_W-1:0]  rs_eol;
	logic [CNT_W-1:0]   bc_inc;
	logic [BYTE_W-1:0]  lit_dec;

	assign in_ready = !valid_s1 || take;
	assign accept   = in_valid && in_ready;
	assign in_pal   = int'(data_byte) < PALETTE_DEPTH;

	// clip the run against the end of the image
	assign room    = (wp_q < geom.limit) ? geom.limit - wp_q : '0;
	assign run_cnt = (phase_q == PH_COLOR) ? pend_q : LEN_W'(1);
	assign run_n   = (PROD_W'(run_cnt) < room) ? run_cnt : room[LEN_W-1:0];
	assign wp_run  = wp_q + PROD_W'(run_n);
	assign rs_eol  = (rs_q >= PROD_W'(geom.width)) ? rs_q - PROD_W'(geom.width) : '0;
	assign bc_inc  = (bc_q != CNT_MAX) ? bc_q + CNT_W'(1) : bc_q;
	assign lit_dec = (lit_q != '0) ? lit_q - BYTE_W'(1) : lit_q;

	always_comb begin
		phase_d = phase_q;
		pend_d  = pend_q;
		lit_d   = lit_q;
		odd_d   = odd_q;
		wp_d    = wp_q;
		rs_d    = rs_q;
		rows_d  = rows_q;
		bc_d    = bc_q;
		fin_d   = fin_q;
		res_v   = 1'b0;
		res_d   = '0;
		if (accept) begin
			case (req_type)
				REQ_START: begin
					phase_d = PH_COUNT;
					pend_d  = '0;
					lit_d   = '0;
					odd_d   = 1'b0;
					wp_d    = geom.start;
					rs_d    = geom.start;
					rows_d  = geom.height;
					bc_d    = '0;
					fin_d   = 1'b0;
				end
				REQ_BYTE: begin
					if (!fin_q) begin
						if (rows_q == '0) begin
							// no rows at all: close without counting the byte
							fin_d          = 1'b1;
							res_v          = 1'b1;
							res_d.done_res = 1'b1;
							res_d.status   = STAT_ROWS;
							res_d.bytes_used = bc_q;
						end else begin
							bc_d = bc_inc;
							unique case (phase_q)
								PH_COUNT: begin
									if (data_byte != '0) begin
										pend_d  = data_byte;
										phase_d = PH_COLOR;
									end else begin
										phase_d = PH_ESCAPE;
									end
								end
								PH_COLOR, PH_LITERAL: begin
									res_v            = 1'b1;
									res_d.pixel_addr = (run_n != '0) ? wp_q[ADDR_W-1:0] : '0;
									res_d.run_len    = run_n;
									res_d.use_pal    = in_pal;
									wp_d             = wp_run;
									if (phase_q == PH_COLOR) begin
										phase_d = PH_COUNT;
									end else begin
										lit_d = lit_dec;
										if (lit_dec == '0) begin
											phase_d = odd_q ? PH_PAD : PH_COUNT;
										end
									end
								end
								PH_ESCAPE: begin
									phase_d = PH_COUNT;
									if (data_byte == ESC_EOL) begin
										rows_d = rows_q - DIM_W'(1);
										rs_d   = rs_eol;
										wp_d   = rs_eol;
										if (rows_q == DIM_W'(1)) begin
											fin_d            = 1'b1;
											res_v            = 1'b1;
											res_d.done_res   = 1'b1;
											res_d.status     = STAT_ROWS;
											res_d.bytes_used = bc_inc;
										end
									end else if (data_byte == ESC_EOB
										|| data_byte == ESC_DELTA) begin
										fin_d            = 1'b1;
										res_v            = 1'b1;
										res_d.done_res   = 1'b1;
										res_d.status     = (data_byte == ESC_EOB) ?
											STAT_EOB : STAT_DELTA;
										res_d.bytes_used = bc_inc;
									end else begin
										lit_d   = data_byte;
										odd_d   = data_byte[0];
										phase_d = PH_LITERAL;
									end
								end
								default: begin
									// pad byte after an odd literal run
									phase_d = PH_COUNT;
								end
							endcase
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		pal_req.we    = accept && (req_type == REQ_PAL) && (int'(pal_index) < PALETTE_DEPTH);
		pal_req.re    = res_v && !res_d.done_res;
		pal_req.addr  = (req_type == REQ_PAL) ? pal_index : data_byte;
		pal_req.wdata = pal_color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_COUNT;
			pend_q   <= '0;
			lit_q    <= '0;
			odd_q    <= 1'b0;
			wp_q     <= '0;
			rs_q     <= '0;
			rows_q   <= DIM_W'(1);
			bc_q     <= '0;
			fin_q    <= 1'b0;
			valid_s1 <= 1'b0;
			res_s1   <= '0;
		end else begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			lit_q   <= lit_d;
			odd_q   <= odd_d;
			wp_q    <= wp_d;
			rs_q    <= rs_d;
			rows_q  <= rows_d;
			bc_q    <= bc_d;
			fin_q   <= fin_d;
			if (in_ready) begin
				valid_s1 <= res_v;
				res_s1   <= res_d;
			end
		end
	end
endmodule

// ===== rtl/rle8_palette.sv =====
// palette memory with registered read
module rle8_palette #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                         clk,
	input  rle8_pkg::pal_req_t           pal_req,
	output logic [rle8_pkg::COLOR_W-1:0] rd_data
);
	import rle8_pkg::*;

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
	logic [COLOR_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (pal_req.we) begin
			mem[pal_req.addr[AW-1:0]] <= pal_req.wdata;
		end
		if (pal_req.re) begin
			rd_q <= mem[pal_req.addr[AW-1:0]];
		end
	end

	assign rd_data = rd_q;
endmodule

// ===== rtl/rle8_out_stage.sv =====
// result register, joins parse result with palette colour
module rle8_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_s1,
	input  rle8_pkg::res_t               res_s1,
	input  logic [rle8_pkg::COLOR_W-1:0] rd_data,
	output logic                         take,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [rle8_pkg::ADDR_W-1:0]  pixel_addr,
	output logic [rle8_pkg::LEN_W-1:0]   run_len,
	output logic [rle8_pkg::COLOR_W-1:0] color,
	output logic                         done_res,
	output rle8_pkg::status_t            status,
	output logic [rle8_pkg::CNT_W-1:0]   bytes_used
);
	import rle8_pkg::*;

	logic               valid_q;
	res_t               res_q;
	logic [COLOR_W-1:0] color_q;

	assign take = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q   <= res_s1;
			// out-of-range index and final results carry colour zero
			color_q <= res_s1.use_pal ? rd_data : '0;
		end
	end

	assign out_valid  = valid_q;
	assign pixel_addr = res_q.pixel_addr;
	assign run_len    = res_q.run_len;
	assign color      = color_q;
	assign done_res   = res_q.done_res;
	assign status     = res_q.status;
	assign bytes_used = res_q.bytes_used;
endmodule

// ===== rtl/rle8_bitmap_decoder_core.sv =====
// BMP RLE8 stream decoder: one request per clock. The parse register captures a result at the
// edge that takes its request, and the output register takes it over at an edge on which
// it is empty or its result is taken. Input stalls only while both registers hold
// results and the receiver holds off. Run results carry start address, clipped length and
// colour; the last result of an image has done_res set with status and bytes consumed. Width
// and height writes apply from the next request and a start request arms a new image; palette
// entries must be written before use.
module rle8_bitmap_decoder_core #(
	parameter int PALETTE_DEPTH = 256,
	parameter int MAX_DIM       = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  rle8_pkg::cfg_idx_t              cfg_index,
	input  logic [rle8_pkg::CFG_DATA_W-1:0] cfg_data,
	rle8_in_if.sink                         in_ch,
	rle8_out_if.source                      out_ch
);
	import rle8_pkg::*;

	geom_t              geom;
	pal_req_t           pal_req;
	logic               valid_s1;
	res_t               res_s1;
	logic               take;
	logic [COLOR_W-1:0] rd_data;

	rle8_cfg #(
		.MAX_DIM(MAX_DIM)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.geom     (geom)
	);

	rle8_parser #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.req_type (in_ch.req_type),
		.pal_index(in_ch.pal_index),
		.pal_color(in_ch.pal_color),
		.data_byte(in_ch.data_byte),
		.take     (take),
		.pal_req  (pal_req),
		.valid_s1 (valid_s1),
		.res_s1   (res_s1)
	);

	rle8_palette #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk    (clk),
		.pal_req(pal_req),
		.rd_data(rd_data)
	);

	rle8_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_s1    (res_s1),
		.rd_data   (rd_data),
		.take      (take),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.pixel_addr(out_ch.pixel_addr),
		.run_len   (out_ch.run_len),
		.color     (out_ch.color),
		.done_res  (out_ch.done_res),
		.status    (out_ch.status),
		.bytes_used(out_ch.bytes_used)
	);
endmodule

// ===== rtl/rle8_checker.sv =====
// port-level checks on the decoder result channel, bound to the top level
`include "rle8_bitmap_decoder_core_macros.svh"

module rle8_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [rle8_pkg::ADDR_W-1:0]  pixel_addr,
	input logic [rle8_pkg::LEN_W-1:0]   run_len,
	input logic [rle8_pkg::COLOR_W-1:0] color,
	input logic                         done_res,
	input rle8_pkg::status_t            status,
	input logic [rle8_pkg::CNT_W-1:0]   bytes_used
);
	import rle8_pkg::*;

	`RLE8_ASSERT_NEXT(a_stall_holds_valid, clk, arst_n, out_valid && !out_ready,
		out_valid, "result request dropped while stalled")

	`RLE8_ASSERT_NEXT(a_stall_holds_data, clk, arst_n, out_valid && !out_ready,
		$stable(pixel_addr) && $stable(run_len) && $stable(color)
			&& $stable(done_res) && $stable(status) && $stable(bytes_used),
		"result request changed while stalled")

	`RLE8_ASSERT_NOW(a_final_has_no_run, clk, arst_n, out_valid && done_res,
		pixel_addr == '0 && run_len == '0 && color == '0,
		"final result carries run fields")

	`RLE8_ASSERT_NOW(a_run_has_no_status, clk, arst_n, out_valid && !done_res,
		status == STAT_EOB && bytes_used == '0,
		"run result carries status fields")

	`RLE8_ASSERT_NOW(a_empty_run_at_zero, clk, arst_n, out_valid && !done_res && run_len == '0,
		pixel_addr == '0, "fully clipped run not reported at address zero")
endmodule

bind rle8_bitmap_decoder_core rle8_checker u_rle8_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.pixel_addr(out_ch.pixel_addr),
	.run_len   (out_ch.run_len),
	.color     (out_ch.color),
	.done_res  (out_ch.done_res),
	.status    (out_ch.status),
	.bytes_used(out_ch.bytes_used)
);
